FILE: design/atan2p_pkg.sv
`default_nettype none
package atan2p_pkg;

    // ratio width and the fraction width of the polynomial datapath
    localparam int RATIO_BITS = 16;
    localparam int WORK_BITS  = 32;

    // minimax coefficients in Q0.32, rounded to nearest
    localparam logic [31:0] CK0 = 32'd106688212;
    localparam logic [31:0] CK1 = 32'd802360794;
    localparam logic [31:0] CK2 = 32'd404147609;
    localparam logic [31:0] CK3 = 32'd1426490580;

    // pi and pi/2 in Q32 fixed point
    localparam logic [33:0] PI_Q32      = 34'd13493037705;
    localparam logic [33:0] HALF_PI_Q32 = 34'd6746518852;

    localparam logic [15:0] RATIO_SAT = 16'hFFFF;

    localparam logic signed [15:0] ANGLE_MAX = 16'sd32767;
    localparam logic signed [15:0] ANGLE_MIN = -16'sd32768;

    // flags carried alongside each item
    typedef struct packed {
        logic swap;
        logic xneg;
        logic yneg;
        logic zero;
        logic eq;
    } flags_t;

endpackage
`default_nettype wire

FILE: design/atan2_polynomial_approx.sv
`default_nettype none
// channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | y_component, x_component
// output   | out_valid | out_stall | angle, both_zero
//
// one item enters per cycle while in_stall is low; the stages are one magnitude stage,
// one stage per quotient bit of the restoring divider (16), and eight stages
// of polynomial multiplies and angle folding.
// rst_n clears all valid bits asynchronously; payload registers are not reset.
// a stall on the output fills empty stages first, so bubbles are squeezed out
// before in_stall rises.
module atan2_polynomial_approx #(
    parameter int INPUT_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire  [INPUT_WIDTH-1:0]       y_component,
    input  wire  [INPUT_WIDTH-1:0]       x_component,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic signed [15:0]           angle,
    output logic                         both_zero
);

    localparam int RB    = atan2p_pkg::RATIO_BITS;
    localparam int DIV0  = 1;
    localparam int P0    = DIV0 + RB;
    localparam int NS    = P0 + 8;
    localparam int SH    = atan2p_pkg::WORK_BITS - ANGLE_FRAC_BITS;
    localparam logic [34:0] RND = 35'd1 << (SH - 1);

    typedef struct packed {
        logic [INPUT_WIDTH:0]   rem;
        logic [INPUT_WIDTH-1:0] mx;
        logic [RB-1:0]          quo;
        atan2p_pkg::flags_t     fl;
    } div_t;

    // valid bits and per-stage advance
    logic [NS-1:0] v_reg;
    logic [NS-1:0] ready;

    always_comb
    begin
        ready[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            ready[k] = !v_reg[k] || ready[k+1];
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (ready[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // magnitudes, compare and sign flags
    logic                   yneg, xneg;
    logic [INPUT_WIDTH-1:0] ay, ax, mx_w, mn_w;
    div_t                   div_reg [0:RB];

    assign yneg = y_component[INPUT_WIDTH-1];
    assign xneg = x_component[INPUT_WIDTH-1];
    assign ay   = yneg ? (~y_component + 1'b1) : y_component;
    assign ax   = xneg ? (~x_component + 1'b1) : x_component;
    assign mx_w = (ay > ax) ? ay : ax;
    assign mn_w = (ay > ax) ? ax : ay;

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            div_reg[0].rem     <= {1'b0, mn_w};
            div_reg[0].mx      <= mx_w;
            div_reg[0].quo     <= '0;
            div_reg[0].fl.swap <= (ay > ax);
            div_reg[0].fl.xneg <= xneg;
            div_reg[0].fl.yneg <= yneg;
            div_reg[0].fl.zero <= (mx_w == '0);
            div_reg[0].fl.eq   <= (mn_w == mx_w);
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar i = 0; i < RB; i++)
    begin : g_div
        logic [INPUT_WIDTH:0] rem2;
        logic                 take;

        assign rem2 = {div_reg[i].rem[INPUT_WIDTH-1:0], 1'b0};
        assign take = rem2 >= {1'b0, div_reg[i].mx};

        always_ff @(posedge clk)
        begin
            if (ready[DIV0+i])
            begin
                div_reg[i+1].rem <= take ? (rem2 - {1'b0, div_reg[i].mx}) : rem2;
                div_reg[i+1].mx  <= div_reg[i].mx;
                div_reg[i+1].quo <= {div_reg[i].quo[RB-2:0], take};
                div_reg[i+1].fl  <= div_reg[i].fl;
            end
        end
    end

    // polynomial stages
    logic [RB-1:0]      a1_reg, a2_reg, a3_reg, a4_reg, a5_reg, a6_reg;
    logic [31:0]        s1_reg, s2_reg, s3_reg;
    logic [31:0]        c2_reg, c3_reg, c4_reg, c5_reg;
    logic [31:0]        q2_reg;
    logic [31:0]        u3_reg, v3_reg, v4_reg, w4_reg, d5_reg, corr6_reg;
    logic [33:0]        r7_reg;
    atan2p_pkg::flags_t f1_reg, f2_reg, f3_reg, f4_reg, f5_reg, f6_reg, f7_reg;

    logic [RB-1:0] ratio_w;
    logic [63:0]   s_full, q_full, u_full, v_full, w_full, corr_full;
    logic [47:0]   c_full;
    logic [31:0]   a32;
    logic [33:0]   r_half;
    logic [33:0]   r_pi;
    logic [34:0]   rsum;
    logic [34:0]   mag;
    logic signed [15:0] ang_w;

    assign ratio_w = div_reg[RB].fl.eq ? atan2p_pkg::RATIO_SAT : div_reg[RB].quo;
    assign s_full  = {48'd0, ratio_w} * {48'd0, ratio_w};
    assign c_full  = {16'd0, s1_reg} * {32'd0, a1_reg};
    assign q_full  = {32'd0, s1_reg} * {32'd0, s1_reg};
    assign u_full  = {32'd0, atan2p_pkg::CK0} * {32'd0, q2_reg};
    assign v_full  = {32'd0, atan2p_pkg::CK2} * {32'd0, q2_reg};
    assign w_full  = {32'd0, u3_reg} * {32'd0, s3_reg};
    assign corr_full = {32'd0, d5_reg} * {32'd0, c5_reg};
    assign a32     = {a6_reg, 16'd0};

    // polynomial correction, then the pi/2 fold for swapped operands
    always_comb
    begin
        logic [31:0] r0;
        r0     = (a32 > corr6_reg) ? (a32 - corr6_reg) : 32'd0;
        r_half = f6_reg.swap ? (atan2p_pkg::HALF_PI_Q32 - {2'b00, r0}) : {2'b00, r0};
    end

    // pi fold, rounding, sign and saturation
    always_comb
    begin
        r_pi = f7_reg.xneg ? ((atan2p_pkg::PI_Q32 > r7_reg) ?
                              (atan2p_pkg::PI_Q32 - r7_reg) : 34'd0) : r7_reg;
        rsum = {1'b0, r_pi} + RND;
        mag  = rsum >> SH;
        if (f7_reg.yneg)
        begin
            ang_w = (mag > 35'd32768) ? atan2p_pkg::ANGLE_MIN : -$signed(mag[15:0]);
        end
        else
        begin
            ang_w = (mag > 35'd32767) ? atan2p_pkg::ANGLE_MAX : $signed(mag[15:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[P0])
        begin
            a1_reg <= ratio_w;
            s1_reg <= s_full[31:0];
            f1_reg <= div_reg[RB].fl;
        end
        if (ready[P0+1])
        begin
            a2_reg <= a1_reg;
            s2_reg <= s1_reg;
            c2_reg <= c_full[47:16];
            q2_reg <= q_full[63:32];
            f2_reg <= f1_reg;
        end
        if (ready[P0+2])
        begin
            a3_reg <= a2_reg;
            s3_reg <= s2_reg;
            c3_reg <= c2_reg;
            u3_reg <= u_full[63:32] + atan2p_pkg::CK1;
            v3_reg <= v_full[63:32] + atan2p_pkg::CK3;
            f3_reg <= f2_reg;
        end
        if (ready[P0+3])
        begin
            a4_reg <= a3_reg;
            c4_reg <= c3_reg;
            v4_reg <= v3_reg;
            w4_reg <= w_full[63:32];
            f4_reg <= f3_reg;
        end
        if (ready[P0+4])
        begin
            a5_reg <= a4_reg;
            c5_reg <= c4_reg;
            d5_reg <= (v4_reg > w4_reg) ? (v4_reg - w4_reg) : 32'd0;
            f5_reg <= f4_reg;
        end
        if (ready[P0+5])
        begin
            a6_reg    <= a5_reg;
            corr6_reg <= corr_full[63:32];
            f6_reg    <= f5_reg;
        end
        if (ready[P0+6])
        begin
            r7_reg <= r_half;
            f7_reg <= f6_reg;
        end
        if (ready[P0+7])
        begin
            angle     <= f7_reg.zero ? 16'sd0 : ang_w;
            both_zero <= f7_reg.zero;
        end
    end

endmodule
`default_nettype wire

FILE: design/atan2_polynomial_approx_chk.sv
`default_nettype none
module atan2_polynomial_approx_chk (
    input wire               clk,
    input wire               rst_n,
    input wire               in_stall,
    input wire               out_valid,
    input wire               out_stall,
    input wire signed [15:0] angle,
    input wire               both_zero
);

    // input held off only while a result waits on a stalled output
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without output back-pressure");

    // zero vector gives zero angle
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && both_zero) |-> (angle == 16'sd0))
        else $error("both_zero with nonzero angle");

    // angle stays within plus or minus pi
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((angle <= 16'sd25736) && (angle >= -16'sd25736)))
        else $error("angle out of range");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(angle) && $stable(both_zero)))
        else $error("stalled result changed");

endmodule

bind atan2_polynomial_approx atan2_polynomial_approx_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .angle     (angle),
    .both_zero (both_zero)
);
`default_nettype wire
